>>> rtl/bpqs_pkg.sv
// Package for the budgeted priority queue selector.
// Holds payload structs, queue and reason codes, and budget defaults.
// No dependencies.
`default_nettype none

package bpqs_pkg;

    localparam int CntW = 8;
    localparam logic [CntW-1:0] CountMax = 8'hff;
    localparam logic [CntW-1:0] DefSuperBudget = 8'd3;
    localparam logic [CntW-1:0] DefL0Budget = 8'd2;
    localparam logic [CntW-1:0] DefFlushBudget = 8'd3;

    typedef enum logic [1:0] {
        Q_SHARED = 2'd0,
        Q_SUPER  = 2'd1,
        Q_FLUSH  = 2'd2,
        Q_COMP   = 2'd3
    } t_queue;

    typedef enum logic [1:0] {
        WHY_STARVED  = 2'd0,
        WHY_BUDGET   = 2'd1,
        WHY_PRIORITY = 2'd2,
        WHY_NONE     = 2'd3
    } t_reason;

    typedef enum logic [1:0] {
        CFG_SUPER_BUDGET = 2'd0,
        CFG_L0_BUDGET    = 2'd1,
        CFG_FLUSH_BUDGET = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [5:0] cpu_index;
        logic [3:0] ready_mask;
        logic [3:0] starved_mask;
    } t_in;

    typedef struct packed {
        logic       granted;
        logic [1:0] queue_choice;
        logic [1:0] grant_reason;
    } t_out;

    typedef struct packed {
        logic [CntW-1:0] super_cnt;
        logic [CntW-1:0] l0_cnt;
        logic [CntW-1:0] flush_cnt;
    } t_counts;

    typedef struct packed {
        logic    we;
        t_counts counts;
    } t_update;

    function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
        return (v == CountMax) ? CountMax : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

>>> rtl/bpqs_count_mem.sv
// Per-CPU run counter memory with registered read, same-edge write bypass,
// and a clearing pass after reset. Depends on bpqs_pkg.
`default_nettype none

module bpqs_count_mem #(
    parameter int CPU_COUNT = 64,
    parameter int AW = 6
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_rd_en,
    input  wire logic [AW-1:0]   i_rd_addr,
    output bpqs_pkg::t_counts    o_rd_data,
    input  wire logic            i_wr_en,
    input  wire logic [AW-1:0]   i_wr_addr,
    input  bpqs_pkg::t_counts    i_wr_data,
    output logic                 o_busy
);
    import bpqs_pkg::*;

    localparam logic [AW-1:0] LastAddr = AW'(CPU_COUNT - 1);

    t_counts       r_mem [CPU_COUNT];
    t_counts       r_rd;
    t_counts       r_byp_data;
    logic          r_byp;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    logic          n_we;
    logic [AW-1:0] n_wa;
    t_counts       n_wd;

    always_comb begin
        if (r_clr_busy) begin
            n_we = 1'b1;
            n_wa = r_clr_addr;
            n_wd = '0;
        end else begin
            n_we = i_wr_en;
            n_wa = i_wr_addr;
            n_wd = i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_wa] <= n_wd;
        end
        if (i_rd_en) begin
            r_rd       <= r_mem[i_rd_addr];
            r_byp_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_byp      <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == LastAddr) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_rd_en) begin
                r_byp <= i_wr_en && !r_clr_busy && (i_wr_addr == i_rd_addr);
            end
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : r_rd;
    assign o_busy    = r_clr_busy;

endmodule

`default_nettype wire

>>> rtl/bpqs_decide.sv
// Queue selection and run counter update for one dispatch request.
// Depends on bpqs_pkg.
`default_nettype none

module bpqs_decide (
    input  bpqs_pkg::t_in        i_item,
    input  wire logic            i_ok,
    input  bpqs_pkg::t_counts    i_counts,
    input  wire logic [7:0]      i_super_limit,
    input  wire logic [7:0]      i_l0_limit,
    input  wire logic [7:0]      i_flush_limit,
    output bpqs_pkg::t_out       o_result,
    output bpqs_pkg::t_update    o_upd
);
    import bpqs_pkg::*;

    logic [3:0] rdy;
    logic [3:0] stv;
    t_queue     q;
    t_reason    why;

    always_comb begin
        rdy = i_item.ready_mask;
        stv = i_item.starved_mask;
        q   = Q_SHARED;
        why = WHY_NONE;
        o_upd.we     = 1'b0;
        o_upd.counts = '0;

        if (stv[Q_SHARED]) begin
            q = Q_SHARED;
            why = WHY_STARVED;
        end else if (stv[Q_SUPER]) begin
            q = Q_SUPER;
            why = WHY_STARVED;
        end else if (stv[Q_FLUSH]) begin
            q = Q_FLUSH;
            why = WHY_STARVED;
        end else if (stv[Q_COMP]) begin
            q = Q_COMP;
            why = WHY_STARVED;
        end else if (i_ok && i_counts.super_cnt >= i_super_limit && rdy[Q_SHARED]) begin
            q = Q_SHARED;
            why = WHY_BUDGET;
            o_upd.we = 1'b1;
        end else if (i_ok && i_counts.l0_cnt >= i_l0_limit && rdy[Q_COMP]) begin
            q = Q_COMP;
            why = WHY_BUDGET;
            o_upd.we = 1'b1;
        end else if (i_ok && i_counts.flush_cnt >= i_flush_limit
                     && (rdy[Q_COMP] || rdy[Q_SHARED])) begin
            q = rdy[Q_COMP] ? Q_COMP : Q_SHARED;
            why = WHY_BUDGET;
            o_upd.we = 1'b1;
        end else if (rdy[Q_SUPER]) begin
            q = Q_SUPER;
            why = WHY_PRIORITY;
            o_upd.we = i_ok;
            o_upd.counts.super_cnt = sat_inc(i_counts.super_cnt);
            o_upd.counts.l0_cnt    = sat_inc(i_counts.l0_cnt);
        end else if (rdy[Q_FLUSH]) begin
            q = Q_FLUSH;
            why = WHY_PRIORITY;
            o_upd.we = i_ok;
            o_upd.counts.flush_cnt = sat_inc(i_counts.flush_cnt);
        end else if (rdy[Q_COMP]) begin
            q = Q_COMP;
            why = WHY_PRIORITY;
            o_upd.we = i_ok;
        end else if (rdy[Q_SHARED]) begin
            q = Q_SHARED;
            why = WHY_PRIORITY;
            o_upd.we = i_ok;
        end

        o_result.granted      = (why != WHY_NONE);
        o_result.queue_choice = q;
        o_result.grant_reason = why;
    end

endmodule

`default_nettype wire

>>> rtl/budgeted_priority_queue_select.sv
// Budgeted priority queue selector, top level.
// A request is registered into stage 1 with its counter read, then its result into the output stage.
// Throughput: one request per cycle while the output is not stalled; the counter memory
// read-modify-write sets it. Reset: budgets return to defaults, and a clearing pass over
// all CPU_COUNT entries zeroes the counter memory while no request is taken.
// Depends on bpqs_pkg, bpqs_count_mem and bpqs_decide.
`default_nettype none

module budgeted_priority_queue_select #(
    parameter int CPU_COUNT = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [7:0]   i_cfg_wdata,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  bpqs_pkg::t_in     i_in_data,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output bpqs_pkg::t_out    o_out_data
);
    import bpqs_pkg::*;

    localparam int AW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;

    logic [7:0] r_super_limit;
    logic [7:0] r_l0_limit;
    logic [7:0] r_flush_limit;
    logic [7:0] n_cfg_value;

    logic    r_s1_valid;
    t_in     r_s1;
    logic    r_s1_ok;
    logic    r_out_valid;
    t_out    r_out;

    logic    in_ok;
    logic    in_fire;
    logic    s1_adv;
    logic    busy;
    logic [AW-1:0] rd_addr;
    t_counts rd_counts;
    t_out    dec_result;
    t_update dec_upd;

    assign n_cfg_value = i_cfg_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_super_limit <= DefSuperBudget;
            r_l0_limit    <= DefL0Budget;
            r_flush_limit <= DefFlushBudget;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SUPER_BUDGET: begin
                    r_super_limit <= (n_cfg_value == '0) ? DefSuperBudget : n_cfg_value;
                end
                CFG_L0_BUDGET: begin
                    r_l0_limit <= (n_cfg_value == '0) ? DefL0Budget : n_cfg_value;
                end
                CFG_FLUSH_BUDGET: begin
                    r_flush_limit <= (n_cfg_value == '0) ? DefFlushBudget : n_cfg_value;
                end
                default: begin
                end
            endcase
        end
    end

    assign in_ok      = 32'(i_in_data.cpu_index) < 32'(CPU_COUNT);
    assign rd_addr    = in_ok ? AW'(i_in_data.cpu_index) : '0;
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !busy && (!r_s1_valid || s1_adv);
    assign in_fire    = i_in_valid && o_in_ready;

    bpqs_count_mem #(
        .CPU_COUNT (CPU_COUNT),
        .AW        (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_fire),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_counts),
        .i_wr_en   (s1_adv && dec_upd.we),
        .i_wr_addr (r_s1_ok ? AW'(r_s1.cpu_index) : '0),
        .i_wr_data (dec_upd.counts),
        .o_busy    (busy)
    );

    bpqs_decide u_decide (
        .i_item        (r_s1),
        .i_ok          (r_s1_ok),
        .i_counts      (rd_counts),
        .i_super_limit (r_super_limit),
        .i_l0_limit    (r_l0_limit),
        .i_flush_limit (r_flush_limit),
        .o_result      (dec_result),
        .o_upd         (dec_upd)
    );

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1    <= i_in_data;
            r_s1_ok <= in_ok;
        end
        if (s1_adv) begin
            r_out <= dec_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> bench/budgeted_priority_queue_select_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for budgeted_priority_queue_select: directed, saturation,
// random and backpressure tests, checked against a grant predictor kept in the bench.
// Depends on bpqs_pkg and the budgeted_priority_queue_select RTL.

module budgeted_priority_queue_select_test;
    import bpqs_pkg::*;

    localparam int CpuCount = 64;
    localparam logic [1:0] CfgNoReg = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_wdata;
    logic in_valid;
    logic in_ready;
    t_in in_data;
    logic out_valid;
    logic out_ready;
    t_out out_data;

    logic [7:0] super_runs [CpuCount];
    logic [7:0] l0_runs [CpuCount];
    logic [7:0] flush_runs [CpuCount];
    logic [7:0] super_limit = DefSuperBudget;
    logic [7:0] l0_limit = DefL0Budget;
    logic [7:0] flush_limit = DefFlushBudget;

    t_out pending_grants[$];
    int errors = 0;
    int send_idle_pct = 28;
    int recv_idle_pct = 64;
    int hold_cycles = 0;

    always #4 clk = ~clk;

    budgeted_priority_queue_select #(
        .CPU_COUNT(CpuCount)
    ) uut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_in_data(in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data(out_data)
    );

    function automatic logic [7:0] run_bump(input logic [7:0] v);
        return (v == 8'hff) ? v : v + 8'd1;
    endfunction

    function automatic void clear_runs(input int c);
        super_runs[c] = '0;
        l0_runs[c] = '0;
        flush_runs[c] = '0;
    endfunction

    function automatic t_out predict_grant(input t_in req);
        int c;
        t_queue q;
        t_reason why;
        logic [7:0] sb;
        logic [7:0] lb;
        logic [7:0] fb;
        t_out res;
        c = req.cpu_index;
        q = Q_SHARED;
        why = WHY_NONE;
        sb = (super_limit != 0) ? super_limit : DefSuperBudget;
        lb = (l0_limit != 0) ? l0_limit : DefL0Budget;
        fb = (flush_limit != 0) ? flush_limit : DefFlushBudget;
        // The lowest numbered starved queue wins; its counters stay as they are.
        for (int i = 3; i >= 0; i--) begin
            if (req.starved_mask[i]) begin
                q = t_queue'(i);
                why = WHY_STARVED;
            end
        end
        if (why == WHY_NONE) begin
            if (super_runs[c] >= sb && req.ready_mask[Q_SHARED]) begin
                q = Q_SHARED;
                why = WHY_BUDGET;
            end else if (l0_runs[c] >= lb && req.ready_mask[Q_COMP]) begin
                q = Q_COMP;
                why = WHY_BUDGET;
            end else if (flush_runs[c] >= fb) begin
                if (req.ready_mask[Q_COMP]) begin
                    q = Q_COMP;
                    why = WHY_BUDGET;
                end else if (req.ready_mask[Q_SHARED]) begin
                    q = Q_SHARED;
                    why = WHY_BUDGET;
                end
            end
            if (why == WHY_BUDGET) clear_runs(c);
        end
        if (why == WHY_NONE) begin
            if (req.ready_mask[Q_SUPER]) begin
                q = Q_SUPER;
                why = WHY_PRIORITY;
                super_runs[c] = run_bump(super_runs[c]);
                l0_runs[c] = run_bump(l0_runs[c]);
                flush_runs[c] = '0;
            end else if (req.ready_mask[Q_FLUSH]) begin
                q = Q_FLUSH;
                why = WHY_PRIORITY;
                super_runs[c] = '0;
                l0_runs[c] = '0;
                flush_runs[c] = run_bump(flush_runs[c]);
            end else if (req.ready_mask[Q_COMP]) begin
                q = Q_COMP;
                why = WHY_PRIORITY;
                clear_runs(c);
            end else if (req.ready_mask[Q_SHARED]) begin
                q = Q_SHARED;
                why = WHY_PRIORITY;
                clear_runs(c);
            end
        end
        res.granted = (why != WHY_NONE);
        res.queue_choice = q;
        res.grant_reason = why;
        return res;
    endfunction

    function automatic t_in make_req(input int cpu, input logic [3:0] ready,
                                     input logic [3:0] starved);
        t_in req;
        req.cpu_index = cpu[5:0];
        req.ready_mask = ready;
        req.starved_mask = starved;
        return req;
    endfunction

    // A few CPUs get most of the requests so that runs build up and budgets force.
    function automatic t_in random_request();
        int cpu;
        logic [3:0] starved;
        cpu = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(3);
        starved = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'd0;
        return make_req(cpu, 4'($urandom_range(15)), starved);
    endfunction

    function automatic logic [7:0] pick_budget();
        case ($urandom_range(5))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd255;
            default: return 8'($urandom_range(6, 2));
        endcase
    endfunction

    task automatic send_request(input t_in req);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        do @(posedge clk); while (!in_ready);
        pending_grants.push_back(predict_grant(req));
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_grants.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_budget(input logic [1:0] index, input logic [7:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (index)
            CFG_SUPER_BUDGET: super_limit = value;
            CFG_L0_BUDGET:    l0_limit = value;
            CFG_FLUSH_BUDGET: flush_limit = value;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic test_directed();
        send_request(make_req(0, 4'b0000, 4'b0000));
        send_request(make_req(63, 4'b1111, 4'b1111));
        send_request(make_req(1, 4'b0000, 4'b0010));
        send_request(make_req(2, 4'b0001, 4'b0100));
        send_request(make_req(3, 4'b0111, 4'b1000));
        repeat (3) send_request(make_req(5, 4'b0010, 4'b0000));
        send_request(make_req(5, 4'b1011, 4'b0000));
        repeat (2) send_request(make_req(5, 4'b1010, 4'b0000));
        send_request(make_req(5, 4'b1010, 4'b0000));
        repeat (3) send_request(make_req(9, 4'b0100, 4'b0000));
        send_request(make_req(9, 4'b1110, 4'b0001));
        send_request(make_req(9, 4'b1101, 4'b0000));
        repeat (3) send_request(make_req(9, 4'b0100, 4'b0000));
        send_request(make_req(9, 4'b0101, 4'b0000));
        repeat (3) send_request(make_req(9, 4'b0100, 4'b0000));
        send_request(make_req(9, 4'b0110, 4'b0000));
        send_request(make_req(0, 4'b1000, 4'b0000));
        send_request(make_req(0, 4'b0001, 4'b0000));
        drain();
    endtask

    // Long runs on one CPU check that the run counters hold at their maximum.
    task automatic test_run_saturation();
        write_budget(CFG_SUPER_BUDGET, 8'd255);
        write_budget(CFG_L0_BUDGET, 8'd255);
        write_budget(CFG_FLUSH_BUDGET, 8'd255);
        repeat (300) send_request(make_req(17, 4'b0010, 4'b0000));
        send_request(make_req(17, 4'b0011, 4'b0000));
        repeat (300) send_request(make_req(17, 4'b0100, 4'b0000));
        send_request(make_req(17, 4'b0101, 4'b0000));
        drain();
        write_budget(CFG_SUPER_BUDGET, 8'd1);
        write_budget(CFG_L0_BUDGET, 8'd1);
        write_budget(CFG_FLUSH_BUDGET, 8'd1);
        write_budget(CfgNoReg, 8'd200);
        send_request(make_req(17, 4'b0010, 4'b0000));
        send_request(make_req(17, 4'b1010, 4'b0000));
        send_request(make_req(17, 4'b0100, 4'b0000));
        send_request(make_req(17, 4'b1101, 4'b0000));
        drain();
        write_budget(CFG_SUPER_BUDGET, 8'd0);
        write_budget(CFG_L0_BUDGET, 8'd0);
        write_budget(CFG_FLUSH_BUDGET, 8'd0);
        repeat (3) send_request(make_req(17, 4'b0010, 4'b0000));
        send_request(make_req(17, 4'b0011, 4'b0000));
        drain();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n);
        drain();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_budget(CFG_SUPER_BUDGET, pick_budget());
        write_budget(CFG_L0_BUDGET, pick_budget());
        write_budget(CFG_FLUSH_BUDGET, pick_budget());
        repeat (n) send_request(random_request());
        drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 200;
        repeat (60) send_request(random_request());
        drain();
    endtask

    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            out_ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string field, input logic [1:0] want,
                                   input logic [1:0] got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
    endtask

    always @(posedge clk) begin : check_grants
        t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_grants.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, actual %p", $time, out_data);
                errors++;
            end else begin
                want = pending_grants.pop_front();
                if (out_data.granted !== want.granted)
                    report_mismatch("granted", {1'b0, want.granted},
                                    {1'b0, out_data.granted});
                if (out_data.queue_choice !== want.queue_choice)
                    report_mismatch("queue_choice", want.queue_choice, out_data.queue_choice);
                if (out_data.grant_reason !== want.grant_reason)
                    report_mismatch("grant_reason", want.grant_reason, out_data.grant_reason);
            end
        end
    end

    initial begin
        for (int i = 0; i < CpuCount; i++) clear_runs(i);
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_run_saturation();
        test_random_traffic(28, 64, 450);
        test_random_traffic(64, 28, 450);
        test_random_traffic(0, 0, 450);
        test_random_traffic(28, 64, 150);
        test_backpressure();
        repeat (10) @(negedge clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
rtl/bpqs_pkg.sv
rtl/bpqs_count_mem.sv
rtl/bpqs_decide.sv
rtl/budgeted_priority_queue_select.sv
bench/budgeted_priority_queue_select_test.sv
